### rtl/core/ddh_pkg.sv
`timescale 1ns / 1ps
package ddh_pkg;

  localparam int MAX_SLOTS_DEF = 1024;
  localparam logic [3:0] CAP_LOG2_RESET = 4'd10;
  localparam logic [63:0] MIX_MULT = 64'hFF51AFD7ED558CCD;
  localparam int MIX_SHIFT = 33;
  localparam logic [31:0] REF_MAX = 32'hFFFFFFFF;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic OP_RESOLVE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic [6:0]  pad;
    logic [31:0] extra_references;
    logic [31:0] free_total;
    logic [31:0] insert_total;
    logic [31:0] hit_total;
    logic [9:0]  longest_probe_seen;
    logic [10:0] live_entries;
    logic        freed;
    logic        shared;
    logic [31:0] physical_id;
    logic [1:0]  status;
  } res_t;

endpackage

### rtl/core/refcounted_dedup_hash_table.sv
`timescale 1ns / 1ps
// Deduplicating hash table with reference counts and linear probing.
// Items enter on the s_ group: s_tuser carries the opcode (resolve or release),
// s_tdata the 64-bit content hash and the 32-bit proposed id. Results leave on
// the m_ group, one per item, in order. The capacity register is written
// through cfg_we and cfg_wdata; the user must write it only while the block is idle,
// since the block itself does not enforce this. The front stage mixes the hash
// with three 32-bit multiplies, one in each of F_M0, F_M1 and F_M2, and takes
// no new item until the last has been pushed on. In the back stage every probe
// step reads the slot memory once. A release that frees an entry also reads each
// slot of the following cluster it visits and probes anew for each entry there.
// A two-entry queue lets the front hash the next item while the back works.
// After reset the slot memory is cleared one slot per cycle, all MAX_SLOTS slots,
// and no item is accepted meanwhile. A result waits in the output register
// while m_tready is low; the back stage holds its next result until it frees.
module refcounted_dedup_hash_table import ddh_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // key_hash, proposed_id
  input  logic [0:0]   s_tuser,   // opcode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [191:0] m_tdata,   // status, physical_id, shared, freed, live_entries,
                                  // longest_probe_seen, hit_total, insert_total,
                                  // free_total, extra_references
  input  logic         cfg_we,
  input  logic [3:0]   cfg_wdata
);

  localparam int IDX_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int LOG_MAX = $clog2(MAX_SLOTS + 1) - 1;
  localparam int REQ_W   = 97 + IDX_W;

  logic [3:0]       cap_log2;
  logic [31:0]      lg_eff;
  logic [IDX_W-1:0] mask;
  logic             clearing;
  logic             fq_valid;
  logic             fq_ready;
  logic [REQ_W-1:0] fq_data;
  logic             qb_valid;
  logic             qb_ready;
  logic [REQ_W-1:0] qb_data;
  res_t             res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_log2 <= CAP_LOG2_RESET;
    end else if (cfg_we) begin
      cap_log2 <= cfg_wdata;
    end
  end

  assign lg_eff  = (32'(cap_log2) > LOG_MAX) ? 32'(LOG_MAX) : 32'(cap_log2);
  assign mask    = IDX_W'((32'd1 << lg_eff) - 32'd1);
  assign m_tdata = res;

  ddh_front #(.IDX_W(IDX_W), .REQ_W(REQ_W)) u_front (
    .clk      (clk),
    .rst      (rst),
    .go       (!clearing),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (s_tuser[0]),
    .in_key   (s_tdata[63:0]),
    .in_prop  (s_tdata[95:64]),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  ddh_queue #(.W(REQ_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  ddh_back #(.MAX_SLOTS(MAX_SLOTS), .IDX_W(IDX_W), .REQ_W(REQ_W)) u_back (
    .clk       (clk),
    .rst       (rst),
    .mask      (mask),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_data    (qb_data),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res),
    .clearing  (clearing)
  );

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("item accepted during the clearing pass");

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(res.live_entries) <= MAX_SLOTS))
    else $error("live entry count exceeds the slot count");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (res.status != ST_OK)) |->
      ((res.physical_id == 32'd0) && !res.shared && !res.freed))
    else $error("error result carries nonzero id or flags");

  a_freed_is_release_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.freed) |-> (!res.shared && (res.status == ST_OK)))
    else $error("freed result with shared flag or error status");

endmodule

### rtl/core/ddh_queue.sv
`timescale 1ns / 1ps
module ddh_queue import ddh_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic [W-1:0] entries [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         push;
  logic         pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### rtl/core/ddh_front.sv
`timescale 1ns / 1ps
module ddh_front import ddh_pkg::*; #(
  parameter int IDX_W = 10,
  parameter int REQ_W = 97 + IDX_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_op,
  input  logic [63:0]      in_key,
  input  logic [31:0]      in_prop,
  output logic             q_valid,
  input  logic             q_ready,
  output logic [REQ_W-1:0] q_data
);

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_M0   = 6'b000010,
    F_M1   = 6'b000100,
    F_M2   = 6'b001000,
    F_MIX  = 6'b010000,
    F_PUSH = 6'b100000
  } fstate_t;

  fstate_t     state;
  logic        op;
  logic [63:0] key;
  logic [31:0] prop;
  logic [63:0] x1;
  logic [63:0] p0;
  logic [31:0] p1;
  logic [31:0] p2;
  logic [IDX_W-1:0] home;
  logic [63:0] prod;
  logic [63:0] mixed;

  assign in_ready = (state == F_IDLE) && go;
  assign q_valid  = (state == F_PUSH);
  assign q_data   = {op, key, prop, home};

  assign prod  = p0 + {p1 + p2, 32'd0};
  assign mixed = prod ^ (prod >> MIX_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid && in_ready) begin
            op    <= in_op;
            key   <= in_key;
            prop  <= in_prop;
            x1    <= in_key ^ (in_key >> MIX_SHIFT);
            state <= F_M0;
          end
        end
        F_M0: begin
          p0    <= 64'(x1[31:0] * MIX_MULT[31:0]);
          state <= F_M1;
        end
        F_M1: begin
          p1    <= 32'(x1[63:32] * MIX_MULT[31:0]);
          state <= F_M2;
        end
        F_M2: begin
          p2    <= 32'(x1[31:0] * MIX_MULT[63:32]);
          state <= F_MIX;
        end
        F_MIX: begin
          home  <= mixed[IDX_W-1:0];
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (q_ready) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/ddh_back.sv
`timescale 1ns / 1ps
module ddh_back import ddh_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  parameter int IDX_W = 10,
  parameter int REQ_W = 97 + IDX_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] mask,
  input  logic             q_valid,
  output logic             q_ready,
  input  logic [REQ_W-1:0] q_data,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res,
  output logic             clearing
);

  typedef enum logic [6:0] {
    B_CLEAR  = 7'b0000001,
    B_IDLE   = 7'b0000010,
    B_RD     = 7'b0000100,
    B_CHK    = 7'b0001000,
    B_RS_RD  = 7'b0010000,
    B_RS_CHK = 7'b0100000,
    B_DONE   = 7'b1000000
  } bstate_t;

  logic [63:0]      mem_key  [MAX_SLOTS];
  logic [31:0]      mem_id   [MAX_SLOTS];
  logic [31:0]      mem_ref  [MAX_SLOTS];
  logic [IDX_W-1:0] mem_home [MAX_SLOTS];

  bstate_t          state;
  logic [IDX_W-1:0] clr;
  logic             op;
  logic [63:0]      pkey;
  logic [31:0]      pprop;
  logic [IDX_W-1:0] phome;
  logic             mode;
  logic [IDX_W-1:0] s;
  logic [IDX_W:0]   pdist;
  logic [IDX_W-1:0] rs_s;
  logic [IDX_W-1:0] rs_n;
  logic [63:0]      hold_key;
  logic [31:0]      hold_id;
  logic [31:0]      hold_ref;
  logic [IDX_W-1:0] hold_home;
  logic [63:0]      rd_key;
  logic [31:0]      rd_id;
  logic [31:0]      rd_ref;
  logic [IDX_W-1:0] rd_home;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [63:0]      wkey;
  logic [31:0]      wid;
  logic [31:0]      wref;
  logic [IDX_W-1:0] whome;
  logic [1:0]       r_status;
  logic [31:0]      r_pid;
  logic             r_shared;
  logic             r_freed;
  logic [IDX_W:0]   occ;
  logic [IDX_W-1:0] record;
  logic [31:0]      hit_cnt;
  logic [31:0]      ins_cnt;
  logic [31:0]      free_cnt;
  logic [31:0]      shr_cnt;
  logic             empty;
  logic             match;
  logic             stop;
  logic             last;
  logic [IDX_W-1:0] s_inc;
  logic [IDX_W-1:0] rs_inc;
  logic [31:0]      occ_ext;
  logic [31:0]      rec_ext;

  assign q_ready  = (state == B_IDLE);
  assign clearing = (state == B_CLEAR);
  assign empty    = (rd_key == 64'd0);
  assign match    = (rd_key == pkey);
  assign stop     = empty || match;
  assign last     = (pdist == {1'b0, mask});
  assign s_inc    = IDX_W'(s + 1'b1) & mask;
  assign rs_inc   = IDX_W'(rs_s + 1'b1) & mask;
  assign rd_en    = (state == B_RD) || ((state == B_RS_RD) && (rs_n != mask));
  assign rd_addr  = (state == B_RD) ? s : rs_s;
  assign occ_ext  = 32'(occ);
  assign rec_ext  = 32'(record);

  always_comb begin
    we    = 1'b0;
    waddr = s;
    wkey  = rd_key;
    wid   = rd_id;
    wref  = rd_ref;
    whome = rd_home;
    case (state)
      B_CLEAR: begin
        we    = 1'b1;
        waddr = clr;
        wkey  = 64'd0;
        wid   = 32'd0;
        wref  = 32'd0;
        whome = '0;
      end
      B_RS_CHK: begin
        we    = !empty;
        waddr = rs_s;
        wkey  = 64'd0;
      end
      B_CHK: begin
        if (mode) begin
          we    = stop || last;
          waddr = stop ? s : rs_s;
          wkey  = hold_key;
          wid   = hold_id;
          wref  = hold_ref;
          whome = hold_home;
        end else if (op == OP_RESOLVE) begin
          we = stop;
          if (empty) begin
            wkey  = pkey;
            wid   = pprop;
            wref  = 32'd1;
            whome = phome;
          end else if (rd_ref != REF_MAX) begin
            wref = rd_ref + 32'd1;
          end
        end else begin
          we = match;
          if (rd_ref <= 32'd1) begin
            wkey = 64'd0;
            wref = 32'd0;
          end else begin
            wref = rd_ref - 32'd1;
          end
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_key[waddr]  <= wkey;
      mem_id[waddr]   <= wid;
      mem_ref[waddr]  <= wref;
      mem_home[waddr] <= whome;
    end
    if (rd_en) begin
      rd_key  <= mem_key[rd_addr];
      rd_id   <= mem_id[rd_addr];
      rd_ref  <= mem_ref[rd_addr];
      rd_home <= mem_home[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr       <= '0;
      res_valid <= 1'b0;
      occ       <= '0;
      record    <= '0;
      hit_cnt   <= 32'd0;
      ins_cnt   <= 32'd0;
      free_cnt  <= 32'd0;
      shr_cnt   <= 32'd0;
    end else begin
      if (res_valid && res_ready && (state != B_DONE)) begin
        res_valid <= 1'b0;
      end
      case (state)
        B_CLEAR: begin
          clr <= IDX_W'(clr + 1'b1);
          if (32'(clr) == MAX_SLOTS - 1) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (q_valid) begin
            {op, pkey, pprop, phome} <= q_data;
            r_pid    <= 32'd0;
            r_shared <= 1'b0;
            r_freed  <= 1'b0;
            mode     <= 1'b0;
            s        <= q_data[IDX_W-1:0] & mask;
            pdist    <= '0;
            if (q_data[REQ_W-2 -: 64] == 64'd0) begin
              r_status <= ST_INVALID;
              state    <= B_DONE;
            end else begin
              r_status <= ST_OK;
              state    <= B_RD;
            end
          end
        end
        B_RD: begin
          state <= B_CHK;
        end
        B_CHK: begin
          if (stop && (pdist > {1'b0, record})) begin
            record <= IDX_W'(pdist);
          end
          if (!(stop || last)) begin
            s     <= s_inc;
            pdist <= pdist + 1'b1;
            state <= B_RD;
          end else if (mode) begin
            rs_s  <= rs_inc;
            rs_n  <= IDX_W'(rs_n + 1'b1);
            state <= B_RS_RD;
          end else if (op == OP_RESOLVE) begin
            state <= B_DONE;
            if (!stop) begin
              r_status <= ST_FULL;
            end else if (empty) begin
              occ     <= occ + 1'b1;
              ins_cnt <= ins_cnt + 32'd1;
              r_pid   <= pprop;
            end else begin
              hit_cnt  <= hit_cnt + 32'd1;
              shr_cnt  <= shr_cnt + 32'd1;
              r_pid    <= rd_id;
              r_shared <= 1'b1;
            end
          end else begin
            if (!match) begin
              r_status <= ST_NOT_FOUND;
              state    <= B_DONE;
            end else begin
              r_pid <= rd_id;
              if (rd_ref <= 32'd1) begin
                occ      <= occ - 1'b1;
                free_cnt <= free_cnt + 32'd1;
                r_freed  <= 1'b1;
                mode     <= 1'b1;
                rs_s     <= s_inc;
                rs_n     <= '0;
                state    <= B_RS_RD;
              end else begin
                shr_cnt <= shr_cnt - 32'd1;
                state   <= B_DONE;
              end
            end
          end
        end
        B_RS_RD: begin
          state <= (rs_n == mask) ? B_DONE : B_RS_CHK;
        end
        B_RS_CHK: begin
          if (empty) begin
            state <= B_DONE;
          end else begin
            hold_key  <= rd_key;
            hold_id   <= rd_id;
            hold_ref  <= rd_ref;
            hold_home <= rd_home;
            pkey      <= rd_key;
            s         <= rd_home & mask;
            pdist     <= '0;
            state     <= B_RD;
          end
        end
        B_DONE: begin
          if (!res_valid || res_ready) begin
            res.pad                <= '0;
            res.status             <= r_status;
            res.physical_id        <= r_pid;
            res.shared             <= r_shared;
            res.freed              <= r_freed;
            res.live_entries       <= occ_ext[10:0];
            res.longest_probe_seen <= rec_ext[9:0];
            res.hit_total          <= hit_cnt;
            res.insert_total       <= ins_cnt;
            res.free_total         <= free_cnt;
            res.extra_references   <= shr_cnt;
            res_valid              <= 1'b1;
            state                  <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

### sim/refcounted_dedup_hash_table_tb.sv
`timescale 1ns / 1ps
module refcounted_dedup_hash_table_tb;
  import ddh_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [95:0]  s_tdata = '0;   // key_hash, proposed_id
  logic [0:0]   s_tuser = '0;   // opcode
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [191:0] m_tdata;        // status, physical_id, shared, freed, live_entries,
                                // longest_probe_seen, hit_total, insert_total,
                                // free_total, extra_references
  logic         cfg_we = 1'b0;
  logic [3:0]   cfg_wdata = '0;

  refcounted_dedup_hash_table u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Mirror of the table contents and statistics.
  logic [63:0] mir_key [MAX_SLOTS_DEF];
  logic [31:0] mir_id [MAX_SLOTS_DEF];
  logic [31:0] mir_refs [MAX_SLOTS_DEF];
  logic [3:0]  mir_cap = CAP_LOG2_RESET;
  int unsigned mir_live = 0;
  int unsigned mir_probe_max = 0;
  logic [31:0] mir_hits = '0, mir_inserts = '0, mir_frees = '0, mir_extra = '0;

  res_t pending_results[$];
  int   mismatches = 0;
  int   results_seen = 0;
  int   items_sent = 0;
  bit   rx_stall = 1'b0;
  event hold_start;
  bit   no_gaps = 1'b0;
  logic [63:0] key_pool[24];

  function automatic logic [63:0] mix_hash(input logic [63:0] k);
    logic [63:0] v;
    v = k ^ (k >> MIX_SHIFT);
    v = v * MIX_MULT;
    return v ^ (v >> MIX_SHIFT);
  endfunction

  function automatic int unsigned active_mask();
    int unsigned m;
    m = (32'd1 << mir_cap) - 1;
    while (m > 0 && m + 1 > MAX_SLOTS_DEF) m = m >> 1;
    return m;
  endfunction

  // Returns the matching or first empty slot, or -1 when every slot in use is taken.
  function automatic int find_slot(input logic [63:0] k, output bit hit);
    int unsigned m, s, probe_len;
    m = active_mask();
    s = 32'(mix_hash(k)) & m;
    hit = 1'b0;
    for (probe_len = 0; probe_len <= m; probe_len++) begin
      if (mir_key[s] == 0 || mir_key[s] == k) begin
        hit = (mir_key[s] != 0);
        if (probe_len > mir_probe_max) mir_probe_max = probe_len;
        return int'(s);
      end
      s = (s + 1) & m;
    end
    return -1;
  endfunction

  function automatic void rehome_cluster(input int unsigned start);
    int unsigned m, s, n;
    int t;
    bit hit;
    logic [63:0] k;
    logic [31:0] id, rc;
    m = active_mask();
    s = (start + 1) & m;
    for (n = 0; n < m && mir_key[s] != 0; n++) begin
      k = mir_key[s];
      id = mir_id[s];
      rc = mir_refs[s];
      mir_key[s] = '0;
      t = find_slot(k, hit);
      if (t < 0) t = s;
      mir_key[t] = k;
      mir_id[t] = id;
      mir_refs[t] = rc;
      s = (s + 1) & m;
    end
  endfunction

  function automatic res_t table_outcome(input logic op, input logic [63:0] k,
                                         input logic [31:0] pid);
    res_t r;
    int s;
    bit hit;
    r = '0;
    r.status = ST_OK;
    if (k == 0) begin
      r.status = ST_INVALID;
    end else if (op == OP_RESOLVE) begin
      s = find_slot(k, hit);
      if (s < 0) begin
        r.status = ST_FULL;
      end else if (hit) begin
        if (mir_refs[s] != REF_MAX) mir_refs[s]++;
        mir_hits++;
        mir_extra++;
        r.physical_id = mir_id[s];
        r.shared = 1'b1;
      end else begin
        mir_key[s] = k;
        mir_id[s] = pid;
        mir_refs[s] = 32'd1;
        mir_live++;
        mir_inserts++;
        r.physical_id = pid;
      end
    end else begin
      s = find_slot(k, hit);
      if (s < 0 || !hit) begin
        r.status = ST_NOT_FOUND;
      end else begin
        r.physical_id = mir_id[s];
        if (mir_refs[s] <= 1) begin
          mir_refs[s] = '0;
          mir_key[s] = '0;
          mir_live--;
          mir_frees++;
          rehome_cluster(s);
          r.freed = 1'b1;
        end else begin
          mir_refs[s]--;
          mir_extra--;
        end
      end
    end
    r.live_entries = mir_live[10:0];
    r.longest_probe_seen = mir_probe_max[9:0];
    r.hit_total = mir_hits;
    r.insert_total = mir_inserts;
    r.free_total = mir_frees;
    r.extra_references = mir_extra;
    return r;
  endfunction

  task automatic send_item(input logic op, input logic [63:0] k, input logic [31:0] pid);
    int gap;
    gap = (!no_gaps && $urandom_range(99) < 34) ? $urandom_range(4, 1) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {pid, k};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(table_outcome(op, k, pid));
    items_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [3:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    mir_cap = v;
  endtask

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch on result %0d, %s: expected %h, got %h", results_seen, name, e, a);
    end
  endtask

  always @(posedge clk) begin
    res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = res_t'(m_tdata);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result arrived with no item outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("physical_id", want.physical_id, got.physical_id);
        check_field("shared", 32'(want.shared), 32'(got.shared));
        check_field("freed", 32'(want.freed), 32'(got.freed));
        check_field("live_entries", 32'(want.live_entries), 32'(got.live_entries));
        check_field("longest_probe_seen", 32'(want.longest_probe_seen),
                    32'(got.longest_probe_seen));
        check_field("hit_total", want.hit_total, got.hit_total);
        check_field("insert_total", want.insert_total, got.insert_total);
        check_field("free_total", want.free_total, got.free_total);
        check_field("extra_references", want.extra_references, got.extra_references);
      end
      results_seen++;
    end
    if (rx_stall) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= no_gaps || ($urandom_range(99) >= 34);
    end
  end

  // Long receiver stall, counted in cycles.
  always begin
    @(hold_start);
    rx_stall <= 1'b1;
    repeat (400) @(posedge clk);
    rx_stall <= 1'b0;
  end

  task automatic test_directed();
    send_item(OP_RESOLVE, 64'd0, 32'hFFFF_FFFF);
    send_item(OP_RELEASE, 64'd0, 32'd0);
    send_item(OP_RELEASE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd5);
    send_item(OP_RESOLVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_RESOLVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd7);
    send_item(OP_RESOLVE, 64'd1, 32'd0);
    send_item(OP_RESOLVE, 64'h8000_0000_0000_0000, 32'h8000_0000);
    send_item(OP_RELEASE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send_item(OP_RELEASE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send_item(OP_RELEASE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send_item(OP_RELEASE, 64'd1, 32'd0);
  endtask

  task automatic test_single_slot();
    set_capacity(4'd0);
    send_item(OP_RESOLVE, 64'h1234_5678_9ABC_DEF0, 32'hA5A5_A5A5);
    send_item(OP_RESOLVE, 64'h0F0F_0F0F_0F0F_0F0F, 32'd1);
    send_item(OP_RESOLVE, 64'h1234_5678_9ABC_DEF0, 32'd2);
    send_item(OP_RELEASE, 64'h1234_5678_9ABC_DEF0, 32'd0);
    send_item(OP_RELEASE, 64'h1234_5678_9ABC_DEF0, 32'd0);
    send_item(OP_RESOLVE, 64'h0F0F_0F0F_0F0F_0F0F, 32'd3);
    send_item(OP_RELEASE, 64'h0F0F_0F0F_0F0F_0F0F, 32'd0);
  endtask

  task automatic test_shrink_while_full();
    set_capacity(4'd2);
    for (int i = 0; i < 5; i++) send_item(OP_RESOLVE, key_pool[i], $urandom);
    set_capacity(4'd1);
    for (int i = 0; i < 5; i++) send_item(OP_RELEASE, key_pool[i], 32'd0);
    for (int i = 0; i < 5; i++) send_item(OP_RESOLVE, key_pool[i], $urandom);
    set_capacity(4'd15);
    for (int i = 0; i < 5; i++) send_item(OP_RESOLVE, key_pool[i], $urandom);
  endtask

  task automatic random_phase(input logic [3:0] cap, input int count, input int pool_size);
    logic [63:0] k;
    int r;
    set_capacity(cap);
    for (int i = 0; i < count; i++) begin
      no_gaps = (i >= count / 2 && i < count / 2 + 30);
      r = $urandom_range(99);
      if (r < 3) k = '0;
      else if (r < 12) k = {$urandom, $urandom};
      else k = key_pool[$urandom_range(pool_size - 1)];
      send_item(($urandom_range(99) < 55) ? OP_RESOLVE : OP_RELEASE, k, $urandom);
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_backpressure();
    wait_drained();
    -> hold_start;
    for (int i = 0; i < 30; i++)
      send_item(1'($urandom_range(1)), key_pool[$urandom_range(15)], $urandom);
  endtask

  initial begin
    for (int i = 0; i < MAX_SLOTS_DEF; i++) begin
      mir_key[i] = '0;
      mir_id[i] = '0;
      mir_refs[i] = '0;
    end
    for (int i = 0; i < 24; i++) key_pool[i] = {$urandom, $urandom | 32'd1};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_single_slot();
    test_shrink_while_full();
    random_phase(4'd3, 120, 12);
    random_phase(4'd10, 120, 24);
    random_phase(4'd1, 60, 6);
    random_phase(4'd4, 100, 24);
    test_backpressure();
    wait_drained();
    $display("Sent %0d items and checked %0d results across capacities 1 to 1024,", items_sent,
             results_seen);
    $display("covering hits, inserts, frees, full table, bad keys and a long output stall.");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("Mismatches: %0d", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### files.f
rtl/core/ddh_pkg.sv
rtl/core/ddh_queue.sv
rtl/core/ddh_front.sv
rtl/core/ddh_back.sv
rtl/core/refcounted_dedup_hash_table.sv
sim/refcounted_dedup_hash_table_tb.sv
